// ----- rtl/core/bde_pkg.sv -----
// shared types, codes and constants of the ducking envelope block
package bde_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int PERIOD_W  = 24;
  localparam int DIV_STEPS = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ANCHOR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_START   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ANCHOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_CTRL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_CTRL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD       = 3'd6;

  // register reset values
  localparam logic [CFG_W-1:0]    RST_LEFT_ANCHOR  = 32'h0000_0000;
  localparam logic [CFG_W-1:0]    RST_LINE_START   = 32'h199A_FFFF;
  localparam logic [CFG_W-1:0]    RST_LINE_END     = 32'hBAE1_FFFF;
  localparam logic [CFG_W-1:0]    RST_RIGHT_ANCHOR = 32'hFFFF_0000;
  localparam logic [CFG_W-1:0]    RST_ATTACK_CTRL  = 32'h0000_FFFF;
  localparam logic [CFG_W-1:0]    RST_DECAY_CTRL   = 32'hFFFF_FFFF;
  localparam logic [PERIOD_W-1:0] RST_PERIOD       = 24'd22050;

  // segment codes
  localparam logic [1:0] SEG_NONE   = 2'd0;
  localparam logic [1:0] SEG_ATTACK = 2'd1;
  localparam logic [1:0] SEG_HOLD   = 2'd2;
  localparam logic [1:0] SEG_DECAY  = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_DIV   = 4'd2;
  localparam logic [3:0] OP_TDONE = 4'd3;
  localparam logic [3:0] OP_UDONE = 4'd4;
  localparam logic [3:0] OP_LDT   = 4'd5;
  localparam logic [3:0] OP_MLO   = 4'd6;
  localparam logic [3:0] OP_MHI   = 4'd7;
  localparam logic [3:0] OP_ACC   = 4'd8;
  localparam logic [3:0] OP_GAIN  = 4'd9;
  localparam logic [3:0] OP_SCL   = 4'd10;
  localparam logic [3:0] OP_SCR   = 4'd11;
  localparam logic [3:0] OP_ADV   = 4'd12;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic [GAIN_W-1:0]          gain_value;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic       use_u;
    logic [1:0] term;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] seg;
  } dp_status_t;

endpackage

// ----- rtl/core/bde_datapath.sv -----
// datapath: registers, counter, shared divider, shared multiplier and scaling
module bde_datapath
  import bde_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_item_t             in_item,
  input  ctl_cmd_t             cmd,
  output dp_status_t           status,
  output out_item_t            result
);

  logic [CFG_W-1:0]      left_anchor, line_start, line_end, right_anchor;
  logic [CFG_W-1:0]      attack_controls, decay_controls;
  logic [PERIOD_W-1:0]   period_length;
  logic [COUNT_BITS-1:0] phase_count, cnt_cur;

  logic [PERIOD_W-1:0] per_eff;
  logic [32:0]         per_ext, cnt_ext, cnt_inc_ext;
  logic [COUNT_BITS-1:0] cnt_eff, cnt_inc;

  logic [PERIOD_W-1:0] rem, den;
  logic [PERIOD_W:0]   rem2;
  logic                div_ge;
  logic [15:0]         quo;
  logic [1:0]          seg, seg_next;
  logic                u_zero, u_full;
  logic [16:0]         u, v;
  logic [63:0]         tval, acc;
  logic [48:0]         plo, mprod;
  logic [31:0]         m_x;
  logic [16:0]         m_f;
  in_item_t            smp;
  logic [SAMPLE_W-1:0] work_l, work_r;
  logic [GAIN_W-1:0]   gain;

  logic [15:0] lx, sx, ex, rx, t, x0, x1, dx, dt;
  logic [17:0] coef;
  logic [63:0] acc_rnd_c, acc_rnd_l;
  logic signed [SAMPLE_W-1:0] s_in;
  logic signed [SAMPLE_W+17:0] sprod;

  // effective period and counter sanitizing
  assign per_eff     = (period_length == '0) ? PERIOD_W'(1) : period_length;
  assign per_ext     = 33'(per_eff);
  assign cnt_ext     = 33'(phase_count);
  assign cnt_eff     = (cnt_ext >= per_ext) ? '0 : phase_count;
  assign cnt_inc     = cnt_cur + COUNT_BITS'(1);
  assign cnt_inc_ext = 33'(cnt_inc);

  // divider step
  assign rem2   = {rem, 1'b0};
  assign div_ge = rem2 >= {1'b0, den};

  // segment selection from phase
  assign lx = left_anchor[31:16];
  assign sx = line_start[31:16];
  assign ex = line_end[31:16];
  assign rx = right_anchor[31:16];
  assign t  = quo;

  always_comb begin
    seg_next = SEG_NONE;
    x0 = ex;
    x1 = rx;
    if (t > lx && t < sx) begin
      seg_next = SEG_ATTACK;
      x0 = lx;
      x1 = sx;
    end else if (t >= sx && t < ex) begin
      seg_next = SEG_HOLD;
      x0 = sx;
      x1 = ex;
    end else if (t >= ex && t <= rx) begin
      seg_next = SEG_DECAY;
    end
  end

  assign dx = x1 - x0;
  assign dt = t - x0;

  // coefficient for the current term
  always_comb begin
    coef = '0;
    case (seg)
      SEG_ATTACK: begin
        case (cmd.term)
          2'd0:    coef = 18'(left_anchor[15:0]);
          2'd1:    coef = 18'({attack_controls[31:16], 1'b0}) + 18'(attack_controls[31:16]);
          2'd2:    coef = 18'({attack_controls[15:0], 1'b0}) + 18'(attack_controls[15:0]);
          default: coef = 18'(line_start[15:0]);
        endcase
      end
      SEG_DECAY: begin
        case (cmd.term)
          2'd0:    coef = 18'(line_end[15:0]);
          2'd1:    coef = 18'({decay_controls[31:16], 1'b0}) + 18'(decay_controls[31:16]);
          2'd2:    coef = 18'({decay_controls[15:0], 1'b0}) + 18'(decay_controls[15:0]);
          default: coef = 18'(right_anchor[15:0]);
        endcase
      end
      default: begin
        coef = (cmd.term == 2'd0) ? 18'(line_start[15:0]) : 18'(line_end[15:0]);
      end
    endcase
  end

  // shared 32x17 multiplier over the two halves of the term
  assign m_x   = (cmd.op == OP_MHI) ? tval[63:32] : tval[31:0];
  assign m_f   = cmd.use_u ? u : v;
  assign mprod = 49'(m_x) * 49'(m_f);

  // rounding of the accumulated polynomial
  assign acc_rnd_c = acc + 64'h0000_8000_0000_0000;
  assign acc_rnd_l = acc + 64'h0000_0000_0000_8000;

  // sample scaling multiplier shared by both channels
  assign s_in  = (cmd.op == OP_SCR) ? smp.sample_right : smp.sample_left;
  assign sprod = (SAMPLE_W+18)'(s_in) * $signed({2'b00, gain})
                 + (SAMPLE_W+18)'(32768);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      left_anchor     <= RST_LEFT_ANCHOR;
      line_start      <= RST_LINE_START;
      line_end        <= RST_LINE_END;
      right_anchor    <= RST_RIGHT_ANCHOR;
      attack_controls <= RST_ATTACK_CTRL;
      decay_controls  <= RST_DECAY_CTRL;
      period_length   <= RST_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEFT_ANCHOR:  left_anchor     <= cfg_data;
        REG_LINE_START:   line_start      <= cfg_data;
        REG_LINE_END:     line_end        <= cfg_data;
        REG_RIGHT_ANCHOR: right_anchor    <= cfg_data;
        REG_ATTACK_CTRL:  attack_controls <= cfg_data;
        REG_DECAY_CTRL:   decay_controls  <= cfg_data;
        REG_PERIOD:       period_length   <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // sample counter
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
    end else if (cmd.op == OP_ADV) begin
      phase_count <= (cnt_inc_ext >= per_ext) ? '0 : cnt_inc;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        smp     <= in_item;
        cnt_cur <= cnt_eff;
        rem     <= PERIOD_W'(33'(cnt_eff));
        den     <= per_eff;
        quo     <= '0;
      end
      OP_DIV: begin
        rem <= div_ge ? PERIOD_W'(rem2 - {1'b0, den}) : rem2[PERIOD_W-1:0];
        quo <= {quo[14:0], div_ge};
      end
      OP_TDONE: begin
        seg    <= seg_next;
        rem    <= PERIOD_W'(dt);
        den    <= PERIOD_W'(dx);
        u_zero <= x1 <= x0;
        u_full <= dt == dx;
      end
      OP_UDONE: begin
        u   <= u_zero ? 17'd0 : (u_full ? 17'h10000 : {1'b0, quo});
        v   <= u_zero ? 17'h10000 : (u_full ? 17'd0 : 17'h10000 - {1'b0, quo});
        acc <= '0;
      end
      OP_LDT: tval <= 64'(coef);
      OP_MLO: plo <= mprod;
      OP_MHI: tval <= {mprod[31:0], 32'd0} + 64'(plo);
      OP_ACC: acc <= acc + tval;
      OP_GAIN: begin
        case (seg)
          SEG_NONE: gain <= '0;
          SEG_HOLD: gain <= acc_rnd_l[31:16];
          default:  gain <= acc_rnd_c[63:48];
        endcase
      end
      // unity gain passes the sample unchanged
      OP_SCL: work_l <= (gain == 16'hFFFF) ? smp.sample_left : sprod[SAMPLE_W+15:16];
      OP_SCR: work_r <= (gain == 16'hFFFF) ? smp.sample_right : sprod[SAMPLE_W+15:16];
      OP_ADV: begin
        result.out_left   <= work_l;
        result.out_right  <= work_r;
        result.gain_value <= gain;
      end
      default: ;
    endcase
  end

  assign status.seg = seg;

endmodule

// ----- rtl/core/bde_ctrl.sv -----
// controller: sequences division, polynomial terms, scaling and output handoff
module bde_ctrl
  import bde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVT  = 4'd1;
  localparam logic [3:0] S_TDONE = 4'd2;
  localparam logic [3:0] S_DIVU  = 4'd3;
  localparam logic [3:0] S_UDONE = 4'd4;
  localparam logic [3:0] S_LDT   = 4'd5;
  localparam logic [3:0] S_MLO   = 4'd6;
  localparam logic [3:0] S_MHI   = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_GAIN  = 4'd9;
  localparam logic [3:0] S_SCL   = 4'd10;
  localparam logic [3:0] S_SCR   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state, state_next;
  logic [3:0] step, step_next;
  logic [1:0] term, term_next;
  logic [1:0] mul, mul_next;
  logic       out_valid_next;
  logic       is_line;
  logic [1:0] last_mul, last_term;
  logic [2:0] mt_sum;

  assign is_line   = status.seg == SEG_HOLD;
  assign last_mul  = is_line ? 2'd0 : 2'd2;
  assign last_term = is_line ? 2'd1 : 2'd3;
  assign mt_sum    = 3'(mul) + 3'(term);
  assign in_ready  = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next     = state;
    step_next      = step;
    term_next      = term;
    mul_next       = mul;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = OP_NOP;
    cmd.term       = term;
    cmd.use_u      = is_line ? (term == 2'd1) : (mt_sum >= 3'd3);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          step_next  = '0;
          state_next = S_DIVT;
        end
      end
      S_DIVT, S_DIVU: begin
        cmd.op    = OP_DIV;
        step_next = step + 4'd1;
        if (step == 4'(DIV_STEPS - 1)) begin
          state_next = (state == S_DIVT) ? S_TDONE : S_UDONE;
        end
      end
      S_TDONE: begin
        cmd.op     = OP_TDONE;
        step_next  = '0;
        state_next = S_DIVU;
      end
      S_UDONE: begin
        cmd.op     = OP_UDONE;
        term_next  = '0;
        state_next = (status.seg == SEG_NONE) ? S_GAIN : S_LDT;
      end
      S_LDT: begin
        cmd.op     = OP_LDT;
        mul_next   = '0;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.op     = OP_MLO;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.op = OP_MHI;
        if (mul == last_mul) begin
          state_next = S_ACC;
        end else begin
          mul_next   = mul + 2'd1;
          state_next = S_MLO;
        end
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (term == last_term) begin
          state_next = S_GAIN;
        end else begin
          term_next  = term + 2'd1;
          state_next = S_LDT;
        end
      end
      S_GAIN: begin
        cmd.op     = OP_GAIN;
        state_next = S_SCL;
      end
      S_SCL: begin
        cmd.op     = OP_SCL;
        state_next = S_SCR;
      end
      S_SCR: begin
        cmd.op     = OP_SCR;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hand the result over once the output register is free
        if (!out_valid || out_ready) begin
          cmd.op         = OP_ADV;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      term      <= '0;
      mul       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      term      <= term_next;
      mul       <= mul_next;
      out_valid <= out_valid_next;
    end
  end

  // an accepted request starts the phase division
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DIVT)
    else $error("request accepted but division not started");

  // phase division always runs its full length
  a_tdiv: assert property (@(posedge clk) disable iff (rst)
    state == S_TDONE |-> $past(state) == S_DIVT && $past(step) == 4'(DIV_STEPS - 1))
    else $error("phase division cut short");

  // a pending result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && out_valid && !out_ready |=> state == S_OUT)
    else $error("result handed over while output busy");

  // the multiply pair never overruns a term
  a_mul: assert property (@(posedge clk) disable iff (rst)
    state == S_MHI |-> mul <= 2'd2)
    else $error("multiply count out of range");

endmodule

// ----- rtl/core/bezier_ducking_envelope_top.sv -----
// top level of the Bezier ducking envelope: controller and datapath
//
//   channel  signals                          payload
//   cfg      cfg_we, cfg_index, cfg_data      register write, no handshake
//   in       in_valid / in_ready              in_item_t  (stereo frame)
//   out      out_valid / out_ready            out_item_t (scaled frame, gain)
//
// one request runs two 16-step divisions on one shared divider, then the
// polynomial terms of its segment on one shared 32x17 multiplier: none outside
// all segments, two line terms in the hold line and four terms in a Bezier segment
// rst is synchronous and restores the register reset values and clears the counter
// a finished result waits in the output register; the next request is taken meanwhile
module bezier_ducking_envelope_top
  import bde_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer
  bde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and storage
  bde_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .result    (out_item)
  );

endmodule
